>>> hw/rtl/text_line_splitter_normalizer_macros.svh
// ----------------------------------------------------------------------------
// Line splitter assertion macros
// Shared concurrent assertion forms for the line splitter checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_SPLITTER_NORMALIZER_MACROS_SVH
`define TEXT_LINE_SPLITTER_NORMALIZER_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define TLSN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define TLSN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tlsn_pkg.sv
// ----------------------------------------------------------------------------
// Line splitter package
// Types, byte codes and register indexes shared by the line splitter modules.
// ----------------------------------------------------------------------------
package tlsn_pkg;

   // most results one input byte can cause
   localparam int BURST_DEPTH = 6;
   localparam int CNT_W       = $clog2(BURST_DEPTH + 1);
   localparam int IDX_W       = $clog2(BURST_DEPTH);

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_DELIM_FIRST   = 2'd0;
   localparam logic [1:0] REG_DELIM_SECOND  = 2'd1;
   localparam logic [1:0] REG_CONVERT_PUNCT = 2'd2;

   localparam logic [7:0] DELIM_RESET = 8'h0A;

   // byte-order mark progress
   localparam logic [1:0] MARK_START = 2'd0;
   localparam logic [1:0] MARK_GOT_A = 2'd1;
   localparam logic [1:0] MARK_GOT_B = 2'd2;
   localparam logic [1:0] MARK_DONE  = 2'd3;

   localparam logic [7:0] BYTE_MARK_A   = 8'hEF;
   localparam logic [7:0] BYTE_MARK_B   = 8'hBB;
   localparam logic [7:0] BYTE_MARK_C   = 8'hBF;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_LSQUOTE  = 8'h91;
   localparam logic [7:0] BYTE_RSQUOTE  = 8'h92;
   localparam logic [7:0] BYTE_LDQUOTE  = 8'h93;
   localparam logic [7:0] BYTE_RDQUOTE  = 8'h94;
   localparam logic [7:0] BYTE_EMDASH   = 8'h97;
   localparam logic [7:0] BYTE_ELLIPSIS = 8'h85;
   localparam logic [7:0] BYTE_UNIT_SEP = 8'h1F;
   localparam logic [7:0] BYTE_APOS     = 8'h27;
   localparam logic [7:0] BYTE_QUOTE    = 8'h22;
   localparam logic [7:0] BYTE_HYPHEN   = 8'h2D;
   localparam logic [7:0] BYTE_DOT      = 8'h2E;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       line_end;
      logic       text_done;
   } rsp_entry_type;

   typedef struct packed {
      logic       line_open;
      logic [1:0] mark_stage;
      logic       cr_held;
   } line_state_type;

   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] cnt;
   } burst_load_type;

endpackage

>>> hw/rtl/tlsn_decode.sv
// ----------------------------------------------------------------------------
// Line splitter decode
// Turns one byte and the line state into its list of results and next state.
// ----------------------------------------------------------------------------
module tlsn_decode (
   input  logic [7:0]               in_byte,
   input  logic                     text_end,
   input  logic [7:0]               delim_first,
   input  logic [7:0]               delim_second,
   input  logic                     convert_punct,
   input  tlsn_pkg::line_state_type state_cur,
   output tlsn_pkg::line_state_type state_next,
   output logic [tlsn_pkg::CNT_W-1:0] res_cnt,
   output tlsn_pkg::rsp_entry_type  res_ent [tlsn_pkg::BURST_DEPTH]
);
   import tlsn_pkg::*;

   function automatic rsp_entry_type char_entry(input logic [7:0] b);
      rsp_entry_type e;
      e.out_byte   = b;
      e.byte_valid = 1'b1;
      e.line_end   = 1'b0;
      e.text_done  = 1'b0;
      return e;
   endfunction

   function automatic rsp_entry_type ctrl_entry(input logic le, input logic td);
      rsp_entry_type e;
      e.out_byte   = 8'h00;
      e.byte_valid = 1'b0;
      e.line_end   = le;
      e.text_done  = td;
      return e;
   endfunction

   logic is_delim;
   assign is_delim = (in_byte == delim_first) || (in_byte == delim_second);

   always_comb begin
      logic [CNT_W-1:0] n;
      logic [1:0]       m;
      logic             c;
      logic             held;
      logic             do_close;

      for (int i = 0; i < BURST_DEPTH; i++) begin
         res_ent[i] = ctrl_entry(1'b0, 1'b0);
      end
      n    = '0;
      held = 1'b0;
      // a new line starts fresh after a delimiter run
      m    = state_cur.line_open ? state_cur.mark_stage : MARK_START;
      c    = state_cur.line_open ? state_cur.cr_held : 1'b0;
      do_close = is_delim ? state_cur.line_open : text_end;

      if (is_delim && !state_cur.line_open && text_end) begin
         res_ent[n[IDX_W-1:0]] = ctrl_entry(1'b0, 1'b1);
         n = n + CNT_W'(1);
      end

      if (!is_delim) begin
         unique case (m)
            MARK_START: begin
               if (in_byte == BYTE_MARK_A) begin
                  m    = MARK_GOT_A;
                  held = 1'b1;
               end
            end
            MARK_GOT_A: begin
               if (in_byte == BYTE_MARK_B) begin
                  m    = MARK_GOT_B;
                  held = 1'b1;
               end else begin
                  res_ent[n[IDX_W-1:0]] = char_entry(BYTE_MARK_A);
                  n = n + CNT_W'(1);
               end
            end
            MARK_GOT_B: begin
               if (in_byte == BYTE_MARK_C) begin
                  m    = MARK_DONE;
                  held = 1'b1;
               end else begin
                  res_ent[n[IDX_W-1:0]] = char_entry(BYTE_MARK_A);
                  n = n + CNT_W'(1);
                  res_ent[n[IDX_W-1:0]] = char_entry(BYTE_MARK_B);
                  n = n + CNT_W'(1);
               end
            end
            default: ;
         endcase

         if (!held) begin
            m = MARK_DONE;
            if (c) begin
               res_ent[n[IDX_W-1:0]] = char_entry(BYTE_CR);
               n = n + CNT_W'(1);
               c = 1'b0;
            end
            if (in_byte == BYTE_CR) begin
               c = 1'b1;
            end else if (convert_punct) begin
               case (in_byte) inside
                  BYTE_LSQUOTE, BYTE_RSQUOTE: begin
                     res_ent[n[IDX_W-1:0]] = char_entry(BYTE_APOS);
                     n = n + CNT_W'(1);
                  end
                  BYTE_LDQUOTE, BYTE_RDQUOTE: begin
                     res_ent[n[IDX_W-1:0]] = char_entry(BYTE_QUOTE);
                     n = n + CNT_W'(1);
                  end
                  BYTE_EMDASH: begin
                     res_ent[n[IDX_W-1:0]] = char_entry(BYTE_HYPHEN);
                     n = n + CNT_W'(1);
                  end
                  BYTE_ELLIPSIS: begin
                     for (int k = 0; k < 3; k++) begin
                        res_ent[n[IDX_W-1:0]] = char_entry(BYTE_DOT);
                        n = n + CNT_W'(1);
                     end
                  end
                  BYTE_UNIT_SEP: ;
                  default: begin
                     res_ent[n[IDX_W-1:0]] = char_entry(in_byte);
                     n = n + CNT_W'(1);
                  end
               endcase
            end else begin
               res_ent[n[IDX_W-1:0]] = char_entry(in_byte);
               n = n + CNT_W'(1);
            end
         end
      end

      if (do_close) begin
         // a partial mark at line end goes out as plain bytes
         if (m == MARK_GOT_A || m == MARK_GOT_B) begin
            res_ent[n[IDX_W-1:0]] = char_entry(BYTE_MARK_A);
            n = n + CNT_W'(1);
         end
         if (m == MARK_GOT_B) begin
            res_ent[n[IDX_W-1:0]] = char_entry(BYTE_MARK_B);
            n = n + CNT_W'(1);
         end
         res_ent[n[IDX_W-1:0]] = ctrl_entry(1'b1, text_end);
         n = n + CNT_W'(1);
      end

      res_cnt = n;

      if (text_end) begin
         state_next.line_open  = 1'b1;
         state_next.mark_stage = MARK_START;
         state_next.cr_held    = 1'b0;
      end else if (is_delim) begin
         state_next.line_open  = 1'b0;
         state_next.mark_stage = state_cur.line_open ? MARK_DONE : state_cur.mark_stage;
         state_next.cr_held    = state_cur.line_open ? 1'b0 : state_cur.cr_held;
      end else begin
         state_next.line_open  = 1'b1;
         state_next.mark_stage = m;
         state_next.cr_held    = c;
      end
   end

endmodule

>>> hw/rtl/tlsn_burst.sv
// ----------------------------------------------------------------------------
// Line splitter result burst buffer
// Holds one byte's results and hands them out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tlsn_burst (
   input  logic                     clock,
   input  logic                     reset,
   input  tlsn_pkg::burst_load_type ld,
   input  tlsn_pkg::rsp_entry_type  ld_ent [tlsn_pkg::BURST_DEPTH],
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_line_end,
   output logic                     rsp_text_done,
   output logic                     rsp_run_last
);
   import tlsn_pkg::*;

   rsp_entry_type    ent_ff [BURST_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last;
   logic             take;
   rsp_entry_type    cur;

   assign rsp_valid = (cnt_ff != '0);
   assign last      = rsp_valid && (CNT_W'(idx_ff) == (cnt_ff - CNT_W'(1)));
   assign take      = rsp_valid && rsp_ready;
   assign free      = !rsp_valid || (take && last);
   assign cur       = ent_ff[idx_ff];

   assign rsp_out_byte   = cur.out_byte;
   assign rsp_byte_valid = cur.byte_valid;
   assign rsp_line_end   = cur.line_end;
   assign rsp_text_done  = cur.text_done;
   assign rsp_run_last   = last;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (ld.load) begin
         cnt_in = ld.cnt;
         idx_in = '0;
      end else if (take) begin
         if (last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.load) begin
         ent_ff <= ld_ent;
      end
   end

endmodule

>>> hw/rtl/text_line_splitter_normalizer.sv
// ----------------------------------------------------------------------------
// Text line splitter and normalizer
// Splits a byte stream into lines, strips byte-order marks and trailing CR,
// and optionally maps Windows-1252 punctuation to ASCII.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  req_     in         one raw text byte plus end-of-text flag
//  rsp_     out        one normalized byte or line/text end marker
//  p*       in/out     APB register access, delimiters and conversion enable
//
// A byte enters the input register, is decoded into 0..6 results once the burst
// buffer is free, and those leave the burst buffer one per cycle while
// rsp_ready is high. Throughput is one byte per cycle while bytes give at most
// one result and rsp_ready is high, else the next byte waits until the last
// result is taken; the single-entry output of the burst buffer sets that.
// Synchronous reset clears control state; no clearing pass is needed.
// A stalled rsp_ready holds the current result; one more byte waits upstream.
// ----------------------------------------------------------------------------
module text_line_splitter_normalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_text_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_line_end,
   output logic        rsp_text_done,
   output logic        rsp_run_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tlsn_pkg::*;

   // configuration registers
   logic [7:0] delim_first_ff, delim_first_in;
   logic [7:0] delim_second_ff, delim_second_in;
   logic       convert_ff, convert_in;
   logic       csr_wr;
   logic [1:0] csr_idx;

   // input register
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff;
   logic       hold_end_ff;

   line_state_type   state_ff, state_in, state_dec;
   logic [CNT_W-1:0] dec_cnt;
   rsp_entry_type    dec_ent [BURST_DEPTH];
   burst_load_type   ld;
   logic             burst_free;
   logic             fire;
   logic             req_take;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      delim_first_in  = delim_first_ff;
      delim_second_in = delim_second_ff;
      convert_in      = convert_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_DELIM_FIRST:   delim_first_in  = pwdata[7:0];
            REG_DELIM_SECOND:  delim_second_in = pwdata[7:0];
            REG_CONVERT_PUNCT: convert_in      = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_DELIM_FIRST:   prdata = {24'h000000, delim_first_ff};
         REG_DELIM_SECOND:  prdata = {24'h000000, delim_second_ff};
         REG_CONVERT_PUNCT: prdata = {31'h00000000, convert_ff};
         default:           prdata = 32'h00000000;
      endcase
   end

   // decode the held byte once the burst buffer can take its results
   assign fire      = hold_valid_ff && burst_free;
   assign req_ready = !hold_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   assign hold_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : hold_valid_ff);
   assign state_in      = fire ? state_dec : state_ff;
   assign ld.load       = fire;
   assign ld.cnt        = dec_cnt;

   tlsn_decode u_decode (
      .in_byte       (hold_byte_ff),
      .text_end      (hold_end_ff),
      .delim_first   (delim_first_ff),
      .delim_second  (delim_second_ff),
      .convert_punct (convert_ff),
      .state_cur     (state_ff),
      .state_next    (state_dec),
      .res_cnt       (dec_cnt),
      .res_ent       (dec_ent)
   );

   tlsn_burst u_burst (
      .clock          (clock),
      .reset          (reset),
      .ld             (ld),
      .ld_ent         (dec_ent),
      .free           (burst_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_line_end   (rsp_line_end),
      .rsp_text_done  (rsp_text_done),
      .rsp_run_last   (rsp_run_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_first_ff       <= DELIM_RESET;
         delim_second_ff      <= DELIM_RESET;
         convert_ff           <= 1'b1;
         hold_valid_ff        <= 1'b0;
         state_ff.line_open   <= 1'b1;
         state_ff.mark_stage  <= MARK_START;
         state_ff.cr_held     <= 1'b0;
      end else begin
         delim_first_ff  <= delim_first_in;
         delim_second_ff <= delim_second_in;
         convert_ff      <= convert_in;
         hold_valid_ff   <= hold_valid_in;
         state_ff        <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_byte_ff <= req_in_byte;
         hold_end_ff  <= req_text_end;
      end
   end

endmodule

>>> hw/rtl/tlsn_checker.sv
// ----------------------------------------------------------------------------
// Line splitter checker
// Port-level assertions on the result channel of the line splitter.
// ----------------------------------------------------------------------------
`include "text_line_splitter_normalizer_macros.svh"

module tlsn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic        rsp_line_end,
   input logic        rsp_text_done,
   input logic        rsp_run_last
);

   logic        rsp_stall;
   logic [11:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_out_byte, rsp_byte_valid, rsp_line_end, rsp_text_done,
                       rsp_run_last};

   // stalled result keeps its payload
   `TLSN_ASSERT(a_rsp_hold, clock, reset,
      rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled result changed")

   // a line end marker never carries a character
   `TLSN_ASSERT(a_end_no_char, clock, reset,
      rsp_valid && rsp_line_end |-> !rsp_byte_valid, "line end carries a character")

   // marker results carry a zero byte
   `TLSN_ASSERT(a_zero_byte, clock, reset,
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'h00, "marker result with nonzero byte")

   // text end is always the last result of its byte
   `TLSN_ASSERT(a_done_last, clock, reset,
      rsp_valid && rsp_text_done |-> rsp_run_last, "text done not last of its byte")

   // nothing pending right after reset
   `TLSN_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind text_line_splitter_normalizer tlsn_checker u_tlsn_checker (.*);
